[rtl/lcas_pkg.sv]
// Shared constants, types and functions of the Life cell-age stencil.
package lcas_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int AGE_BITS = 8;
  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int DIM_BITS = 11;
  localparam int ROW_BITS = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CELL_BITS = AGE_BITS + 1;
  localparam int LINE_BITS = 2 * CELL_BITS;
  localparam int WIN_BITS = 9;
  localparam int CNT_BITS = 4;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [DIM_BITS-1:0] DIM_MIN = DIM_BITS'(3);
  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(64);
  localparam logic [DIM_BITS-1:0] WIDTH_LIMIT = DIM_BITS'(MAX_WIDTH);
  localparam logic [DIM_BITS-1:0] HEIGHT_LIMIT = DIM_BITS'(MAX_HEIGHT);

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = CFG_INDEX_BITS'(1);

  localparam logic [CNT_BITS-1:0] BIRTH_COUNT = CNT_BITS'(3);
  localparam logic [CNT_BITS-1:0] STAY_COUNT = CNT_BITS'(2);

  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic                bot;
    logic [AGE_BITS-1:0] bot_age;
    logic                use_top;
    logic                use_mid;
    logic                emit_edge;
    logic                emit_mid;
    logic                first_col;
    logic                last;
  } pos_info_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] hi);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (r < DIM_MIN) r = DIM_MIN;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic logic life_rule(input logic [CNT_BITS-1:0] cnt, input logic alive);
    return (cnt == BIRTH_COUNT) || (alive && (cnt == STAY_COUNT));
  endfunction

endpackage

[rtl/lcas_line_store.sv]
// Line store memory holding the two previous rows, registered read.
module lcas_line_store (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [lcas_pkg::COL_BITS-1:0]  rd_addr,
  output logic [lcas_pkg::LINE_BITS-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [lcas_pkg::COL_BITS-1:0]  wr_addr,
  input  logic [lcas_pkg::LINE_BITS-1:0] wr_data
);
  import lcas_pkg::*;

  logic [LINE_BITS-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/lcas_pos.sv]
// Grid size registers and raster position tracking of incoming items.
module lcas_pos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcas_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lcas_pkg::DIM_BITS-1:0]       cfg_data,
  input  logic                              accept,
  input  logic                              mode,
  input  logic                              cell_alive,
  input  logic [lcas_pkg::AGE_BITS-1:0]       cell_age,
  output lcas_pkg::pos_info_t               info
);
  import lcas_pkg::*;

  logic [DIM_BITS-1:0] width_used;
  logic [DIM_BITS-1:0] height_used;
  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col_next;
  logic [ROW_BITS-1:0] row_next;
  logic                in_grid;
  logic                wrap_frame;
  logic                wrap_row;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_grid = !mode && (row < height_used);
    wrap_frame = (col == '0) && (row >= height_used + ROW_BITS'(1));
    wrap_row = ({1'b0, col} + DIM_BITS'(1)) >= width_used;
    if (wrap_frame) begin
      col_next = '0;
      row_next = '0;
    end else if (wrap_row) begin
      col_next = '0;
      row_next = row + ROW_BITS'(1);
    end else begin
      col_next = col + COL_BITS'(1);
      row_next = row;
    end
  end

  always_comb begin
    info.col = col;
    info.bot = in_grid & cell_alive;
    info.bot_age = in_grid ? cell_age : '0;
    info.use_top = row >= ROW_BITS'(2);
    info.use_mid = row != '0;
    info.emit_edge = (col == '0) && (row >= ROW_BITS'(2));
    info.emit_mid = (col != '0) && (row != '0);
    info.first_col = col == COL_BITS'(1);
    info.last = (col == '0) && (row == height_used + ROW_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_used <= DIM_RESET;
      height_used <= DIM_RESET;
      col <= '0;
      row <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: begin
          width_used <= clamp_dim(cfg_data, WIDTH_LIMIT);
          col <= '0;
          row <= '0;
        end
        REG_GRID_HEIGHT: begin
          height_used <= clamp_dim(cfg_data, HEIGHT_LIMIT);
          col <= '0;
          row <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

[rtl/lcas_window.sv]
// 3x3 window, neighbour count, Life rule, age update and result register.
module lcas_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           fire,
  input  lcas_pkg::pos_info_t            info,
  input  logic [lcas_pkg::LINE_BITS-1:0] rd_data,
  output logic                           wr_en,
  output logic [lcas_pkg::COL_BITS-1:0]  wr_addr,
  output logic [lcas_pkg::LINE_BITS-1:0] wr_data,
  output logic                           out_valid,
  output logic                           next_alive,
  output logic [lcas_pkg::AGE_BITS-1:0]  next_age,
  output logic                           frame_last
);
  import lcas_pkg::*;

  logic [WIN_BITS-1:0] win;
  logic [AGE_BITS-1:0] centre_age;
  logic [WIN_BITS-1:0] win_next;
  logic                top_bit;
  logic                mid_bit;
  logic [AGE_BITS-1:0] mid_age;
  logic [CNT_BITS-1:0] edge_cnt;
  logic [CNT_BITS-1:0] mid_cnt;
  logic                edge_alive;
  logic                mid_alive;
  logic                res_alive;
  logic                emits;
  logic [AGE_BITS-1:0] age_inc;

  always_comb begin
    top_bit = info.use_top & rd_data[LINE_BITS-1];
    mid_bit = info.use_mid & rd_data[CELL_BITS-1];
    mid_age = info.use_mid ? rd_data[AGE_BITS-1:0] : '0;
    win_next = {info.bot, mid_bit, top_bit, win[WIN_BITS-1:3]};

    edge_cnt = CNT_BITS'(win[3]) + CNT_BITS'(win[4]) + CNT_BITS'(win[5])
             + CNT_BITS'(win[6]) + CNT_BITS'(win[8]);
    edge_alive = life_rule(edge_cnt, win[7]);

    mid_cnt = CNT_BITS'(win_next[3]) + CNT_BITS'(win_next[5])
            + CNT_BITS'(win_next[6]) + CNT_BITS'(win_next[7]) + CNT_BITS'(win_next[8]);
    if (!info.first_col) begin
      mid_cnt = mid_cnt + CNT_BITS'(win_next[0]) + CNT_BITS'(win_next[1])
              + CNT_BITS'(win_next[2]);
    end
    mid_alive = life_rule(mid_cnt, win_next[4]);

    res_alive = info.emit_edge ? edge_alive : mid_alive;
    emits = info.emit_edge | info.emit_mid;
    age_inc = (centre_age == AGE_MAX) ? AGE_MAX : centre_age + AGE_BITS'(1);
  end

  assign wr_en = fire;
  assign wr_addr = info.col;
  assign wr_data = {rd_data[CELL_BITS-1:0], info.bot, info.bot_age};

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      centre_age <= '0;
    end else if (fire) begin
      win <= win_next;
      centre_age <= mid_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire & emits;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && emits) begin
      next_alive <= res_alive;
      next_age <= res_alive ? age_inc : '0;
      frame_last <= info.emit_edge & info.last;
    end
  end

endmodule

[rtl/life_cell_age_stencil.sv]
// Timing: an accepted item and its line store read are registered in the s1 registers,
// and the result it completes is loaded into the output register when s1 fires. A centre
// cell's result comes out with the item W+1 positions after it.
// Throughput: 1 item per cycle unless the output stalls, set by the line store ports.
// Reset: grid size 64 x 64, position row 0 column 0, no result pending.
// Line store contents are not cleared; each entry is written before its value is used.
module life_cell_age_stencil (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic                                cell_alive,
  input  logic [lcas_pkg::AGE_BITS-1:0]       cell_age,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                next_alive,
  output logic [lcas_pkg::AGE_BITS-1:0]       next_age,
  output logic                                frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcas_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lcas_pkg::DIM_BITS-1:0]       cfg_data
);
  import lcas_pkg::*;

  logic                 advance;
  logic                 accept;
  logic                 fire;
  logic                 s1_valid;
  pos_info_t            pos_info;
  pos_info_t            s1_info;
  logic [LINE_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [COL_BITS-1:0]  wr_addr;
  logic [LINE_BITS-1:0] wr_data;

  assign advance = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept = in_valid && advance;
  assign fire = advance && s1_valid;

  lcas_pos u_pos (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .mode       (mode),
    .cell_alive (cell_alive),
    .cell_age   (cell_age),
    .info       (pos_info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= pos_info;
    end
  end

  lcas_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos_info.col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lcas_window u_window (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .fire       (fire),
    .info       (s1_info),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .out_valid  (out_valid),
    .next_alive (next_alive),
    .next_age   (next_age),
    .frame_last (frame_last)
  );

endmodule

[sim/tb_life_cell_age_stencil.sv]
// Self-checking testbench for the Life cell-age stencil: directed frames, extreme sizes, random.
`timescale 1ns / 1ps

module tb_life_cell_age_stencil;
  import lcas_pkg::*;

  localparam logic MODE_CELL = 1'b0;
  localparam logic MODE_PAD = 1'b1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VOID_A = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_VOID_B = CFG_INDEX_BITS'(3);
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS = 200;

  typedef struct packed {
    logic                alive;
    logic [AGE_BITS-1:0] age;
    logic                last;
  } fate_t;

  class cell_fate_board;
    logic [CELL_BITS-1:0] line_above[MAX_WIDTH];
    logic [CELL_BITS-1:0] line_middle[MAX_WIDTH];
    logic [WIN_BITS-1:0]  win;
    logic [AGE_BITS-1:0]  mid_row_ages[3];
    int unsigned          col;
    int unsigned          row;
    logic [DIM_BITS-1:0]  width_reg;
    logic [DIM_BITS-1:0]  height_reg;
    fate_t                fates_due[$];
    int                   faults;

    function new();
      foreach (line_above[i]) begin
        line_above[i] = '0;
        line_middle[i] = '0;
      end
      win = '0;
      foreach (mid_row_ages[i]) mid_row_ages[i] = '0;
      col = 0;
      row = 0;
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      faults = 0;
    endfunction

    function int unsigned span(logic [DIM_BITS-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function bit in_rows();
      return row < span(height_reg, MAX_HEIGHT);
    endfunction

    function bit at_origin();
      return row == 0 && col == 0;
    endfunction

    function int pending();
      return fates_due.size();
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
      if (idx == REG_GRID_WIDTH) width_reg = val;
      else if (idx == REG_GRID_HEIGHT) height_reg = val;
      else return;
      col = 0;
      row = 0;
    endfunction

    function fate_t fate_at(int lo, int mid, logic [AGE_BITS-1:0] age, logic last);
      int cnt;
      int cc;
      int rr;
      fate_t f;
      cnt = 0;
      for (cc = lo; cc <= 2; cc++)
        for (rr = 0; rr < 3; rr++)
          if (!(cc == mid && rr == 1)) cnt += win[3 * cc + rr];
      f.alive = (cnt == 3) || (win[3 * mid + 1] && cnt == 2);
      f.age = !f.alive ? '0 : (age == AGE_MAX) ? AGE_MAX : age + 1'b1;
      f.last = last;
      return f;
    endfunction

    function void take_cell(logic md, logic alive, logic [AGE_BITS-1:0] age);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic bot;
      logic [AGE_BITS-1:0] bot_age;
      logic [CELL_BITS-1:0] above;
      logic [CELL_BITS-1:0] middle;
      logic top_bit;
      logic mid_bit;
      logic [AGE_BITS-1:0] mid_age;
      bit emitted;
      w = span(width_reg, MAX_WIDTH);
      h = span(height_reg, MAX_HEIGHT);
      r = row;
      c = col;
      if (md == MODE_CELL && r < h) begin
        bot = alive;
        bot_age = age;
      end else begin
        bot = 1'b0;
        bot_age = '0;
      end
      if (c >= w) c = w - 1;
      above = line_above[c];
      middle = line_middle[c];
      top_bit = (r >= 2) ? above[AGE_BITS] : 1'b0;
      mid_bit = (r >= 1) ? middle[AGE_BITS] : 1'b0;
      mid_age = (r >= 1) ? middle[AGE_BITS-1:0] : '0;
      emitted = 0;
      if (c == 0 && r >= 2) begin
        fates_due.push_back(fate_at(1, 2, mid_row_ages[2], r == h + 1));
        emitted = 1;
      end
      win = {bot, mid_bit, top_bit, win[WIN_BITS-1:3]};
      mid_row_ages[0] = mid_row_ages[1];
      mid_row_ages[1] = mid_row_ages[2];
      mid_row_ages[2] = mid_age;
      line_above[c] = middle;
      line_middle[c] = {bot, bot_age};
      if (c >= 1 && r >= 1 && !emitted) fates_due.push_back(fate_at((c == 1) ? 1 : 0, 1,
                                                                   mid_row_ages[1], 1'b0));
      if (c == 0 && r >= h + 1) begin
        col = 0;
        row = 0;
      end else if (c + 1 >= w) begin
        col = 0;
        row = r + 1;
      end else begin
        col = c + 1;
        row = r;
      end
    endfunction

    function void check_fate(logic alive, logic [AGE_BITS-1:0] age, logic last);
      fate_t exp_f;
      if (fates_due.size() == 0) begin
        $error("result with nothing expected: next_alive %0d next_age %0d frame_last %0d",
               alive, age, last);
        faults++;
        return;
      end
      exp_f = fates_due.pop_front();
      if (alive !== exp_f.alive) begin
        $error("next_alive: expected %0d, got %0d", exp_f.alive, alive);
        faults++;
      end
      if (age !== exp_f.age) begin
        $error("next_age: expected %0d, got %0d", exp_f.age, age);
        faults++;
      end
      if (last !== exp_f.last) begin
        $error("frame_last: expected %0d, got %0d", exp_f.last, last);
        faults++;
      end
    endfunction

    function void close_out();
      if (fates_due.size() != 0) begin
        $error("%0d expected results never came", fates_due.size());
        faults++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic mode;
  logic cell_alive;
  logic [AGE_BITS-1:0] cell_age;
  logic out_valid;
  logic out_stall = 1'b0;
  logic next_alive;
  logic [AGE_BITS-1:0] next_age;
  logic frame_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [DIM_BITS-1:0] cfg_data;

  cell_fate_board board;
  bit quiet = 1'b0;
  int gap_pct = 0;
  int fed = 0;
  int stall_left = 0;
  int calm_left = 0;

  life_cell_age_stencil i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .cell_alive (cell_alive),
    .cell_age   (cell_age),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_alive (next_alive),
    .next_age   (next_age),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else begin
      out_stall <= 1'b0;
      calm_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      stall_left <= $urandom_range(1, 9);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_fate(next_alive, next_age, frame_last);
  end

  task automatic feed(input logic md, input logic al, input logic [AGE_BITS-1:0] ag);
    in_valid <= 1'b1;
    mode <= md;
    cell_alive <= al;
    cell_age <= ag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_cell(md, al, ag);
    fed++;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic feed_random(input int dens, input int noise);
    logic md;
    logic al;
    logic [AGE_BITS-1:0] ag;
    if (board.in_rows()) md = ($urandom_range(0, 99) < noise) ? MODE_PAD : MODE_CELL;
    else md = ($urandom_range(0, 99) < 20) ? MODE_CELL : MODE_PAD;
    al = $urandom_range(0, 99) < dens;
    ag = ($urandom_range(0, 3) == 0) ? AGE_BITS'($urandom_range(250, 255))
                                     : AGE_BITS'($urandom_range(0, 255));
    feed(md, al, ag);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [DIM_BITS-1:0] val,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [AGE_BITS-1:0] block_ages[9];
    int k;
    int dens;
    int target;
    bit hold_on;
    block_ages = '{8'd255, 8'd0, 8'd254, 8'd7, 8'd255, 8'd100, 8'd254, 8'd1, 8'd255};
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_CELL;
    cell_alive = 1'b0;
    cell_age = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // 3x3 block: corners survive with saturating ages, padding rows carry live cells
    gap_pct = 30;
    write_reg(REG_GRID_WIDTH, DIM_BITS'(0), 1);
    write_reg(REG_GRID_HEIGHT, DIM_BITS'(2), 0);
    for (k = 0; k < 9; k++) feed(MODE_CELL, 1'b1, block_ages[k]);
    repeat (3) feed(MODE_CELL, 1'b1, AGE_MAX);
    feed(MODE_PAD, 1'b0, '0);

    // birth in the centre cell of a padding row inside the frame
    feed(MODE_CELL, 1'b1, 8'd9);
    feed(MODE_CELL, 1'b0, 8'd200);
    feed(MODE_CELL, 1'b1, 8'd30);
    repeat (3) feed(MODE_PAD, 1'b1, AGE_MAX);
    feed(MODE_CELL, 1'b0, '0);
    feed(MODE_CELL, 1'b1, 8'd55);
    feed(MODE_CELL, 1'b0, '0);
    repeat (4) feed(MODE_PAD, 1'b0, '0);

    // extreme sizes
    settle();
    write_reg(REG_GRID_WIDTH, '1, 1);
    write_reg(REG_GRID_HEIGHT, DIM_BITS'(1025), 0);
    gap_pct = 10;
    repeat (40) feed_random(40, 5);
    settle();
    write_reg(REG_GRID_WIDTH, DIM_BITS'(1024), 1);
    write_reg(REG_GRID_HEIGHT, DIM_BITS'(3), 0);
    repeat (40) feed_random(35, 3);
    settle();
    write_reg(REG_GRID_WIDTH, DIM_BITS'(3), 1);
    write_reg(REG_GRID_HEIGHT, '1, 0);
    repeat (60) feed_random(45, 3);

    // random sizes, mostly whole frames
    target = fed + RANDOM_ITEMS;
    while (fed < target) begin
      settle();
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      dens = $urandom_range(15, 65);
      hold_on = $urandom_range(0, 4) == 0;
      write_reg(REG_GRID_WIDTH, DIM_BITS'($urandom_range(0, 12)), 1);
      write_reg(REG_GRID_HEIGHT, DIM_BITS'($urandom_range(0, 9)), hold_on);
      if (hold_on) write_reg($urandom_range(0, 1) ? REG_VOID_A : REG_VOID_B,
                             DIM_BITS'($urandom), 0);
      case ($urandom_range(0, 5))
        0: begin
          repeat ($urandom_range(1, 60)) feed_random(dens, 8);
        end
        1: begin
          repeat ($urandom_range(1, 30)) feed_random(dens, 8);
          settle();
          write_reg($urandom_range(0, 1) ? REG_VOID_A : REG_VOID_B, DIM_BITS'($urandom), 0);
          do feed_random(dens, 8); while (!board.at_origin());
        end
        default: begin
          repeat ($urandom_range(1, 2)) begin
            do feed_random(dens, 8); while (!board.at_origin());
          end
        end
      endcase
    end

    // steady flow at the end
    settle();
    quiet <= 1'b1;
    gap_pct = 0;
    write_reg(REG_GRID_WIDTH, DIM_BITS'($urandom_range(3, 10)), 1);
    write_reg(REG_GRID_HEIGHT, DIM_BITS'($urandom_range(3, 8)), 0);
    do feed_random(40, 5); while (!board.at_origin());
    in_valid <= 1'b0;
    for (k = 0; k < 5000 && board.pending() != 0; k++) @(posedge clk);
    repeat (8) @(negedge clk);
    board.close_out();
    if (board.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
